@@ sv/scpi_pkg.sv @@
// Shared types, constants and helper functions for the sound chip port interface.
// No dependencies; imported by scpi_exec and the top level.
package scpi_pkg;

    localparam int NUM_CHIPS_DEF        = 5;
    localparam int NUM_STORED_CHIPS_DEF = 3;
    localparam int REGS_PER_CHIP        = 16;

    localparam logic [7:0]  PORT_LIMIT      = 8'h12;
    localparam logic [5:0]  TIMER_CHIP      = 6'd2;
    localparam logic [3:0]  TIMER_REG       = 4'd14;
    localparam logic [13:0] COUNT_WRAP      = 14'd10240;
    localparam logic [9:0]  TICK_STEP_RESET = 10'd40;
    localparam logic [7:0]  BUS_IDLE        = 8'hFF;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        FN_ADDR = 2'd0,
        FN_READ = 2'd1,
        FN_DATA = 2'd2,
        FN_NONE = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] port;
        logic [7:0] data;
    } item_t;

    // Timer readback table, indexed by cycle_count / 1024 (clamped to 9).
    function automatic logic [7:0] timer_value(input logic [3:0] idx);
        logic [7:0] val;
        case (idx)
            4'd0:    val = 8'h00;
            4'd1:    val = 8'h01;
            4'd2:    val = 8'h02;
            4'd3:    val = 8'h03;
            4'd4:    val = 8'h04;
            4'd5:    val = 8'h09;
            4'd6:    val = 8'h0a;
            4'd7:    val = 8'h0b;
            4'd8:    val = 8'h0a;
            default: val = 8'h0d;
        endcase
        return val;
    endfunction

endpackage

@@ sv/scpi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/scpi_exec.sv @@
// Execute stage: address latches, register-file valid bits, tick counter and result mux.
// Depends on scpi_pkg; drives the write port and read port of an external scpi_ram.
module scpi_exec #(
    parameter int NUM_CHIPS        = scpi_pkg::NUM_CHIPS_DEF,
    parameter int NUM_STORED_CHIPS = scpi_pkg::NUM_STORED_CHIPS_DEF,
    localparam int RAM_DEPTH       = NUM_STORED_CHIPS * scpi_pkg::REGS_PER_CHIP,
    localparam int RAM_AW          = $clog2(RAM_DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [9:0]          cfg_wr_data,
    input  logic                exec_en,
    input  scpi_pkg::item_t     exec_item,
    input  logic                acc_en,
    input  logic [7:0]          acc_port,
    output logic                ram_wr_en,
    output logic [RAM_AW-1:0]   ram_wr_addr,
    output logic [7:0]          ram_wr_data,
    output logic                ram_rd_en,
    output logic [RAM_AW-1:0]   ram_rd_addr,
    input  logic [7:0]          ram_rd_data,
    output logic [7:0]          result
);

    import scpi_pkg::*;

    localparam int CHIP_W = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;

    logic [3:0]           latch_reg [NUM_CHIPS];
    logic [RAM_DEPTH-1:0] ram_vld_reg;
    logic [13:0]          cycle_count_reg, cycle_count_next;
    logic [9:0]           tick_step_reg;
    logic                 fwd_hit_reg, rd_vld_reg;
    logic [7:0]           fwd_data_reg;

    op_t                  x_op;
    func_t                x_func;
    logic [5:0]           x_chip, a_chip;
    logic                 x_mapped, x_stored, x_latch_we, x_ram_we;
    logic [CHIP_W-1:0]    x_idx, a_idx;
    logic [3:0]           x_reg, a_reg;
    logic                 a_known, a_stored, fwd_hit;
    logic [14:0]          count_sum;
    logic [7:0]           stored_data;

    // Decode of the transaction being executed
    always_comb begin
        x_op       = op_t'(exec_item.opcode);
        x_func     = func_t'(exec_item.port[1:0]);
        x_chip     = exec_item.port[7:2];
        x_mapped   = (exec_item.port <= PORT_LIMIT) && (x_chip < 6'(NUM_CHIPS));
        x_stored   = x_chip < 6'(NUM_STORED_CHIPS);
        x_idx      = x_mapped ? x_chip[CHIP_W-1:0] : '0;
        x_reg      = latch_reg[x_idx];
        x_latch_we = (x_op == OP_WRITE) && x_mapped && (x_func == FN_ADDR);
        x_ram_we   = (x_op == OP_WRITE) && x_mapped && (x_func == FN_DATA) && x_stored;
    end

    assign ram_wr_en   = exec_en && x_ram_we;
    assign ram_wr_addr = RAM_AW'({x_chip, x_reg});
    assign ram_wr_data = exec_item.data;

    // Read address for the transaction being accepted; forward a latch write
    // made by the executing transaction in the same cycle.
    always_comb begin
        a_chip   = acc_port[7:2];
        a_known  = a_chip < 6'(NUM_CHIPS);
        a_stored = a_chip < 6'(NUM_STORED_CHIPS);
        a_idx    = a_known ? a_chip[CHIP_W-1:0] : '0;
        if (exec_en && x_latch_we && (x_idx == a_idx)) begin
            a_reg = exec_item.data[3:0];
        end else begin
            a_reg = latch_reg[a_idx];
        end
        ram_rd_addr = a_stored ? RAM_AW'({a_chip, a_reg}) : '0;
        fwd_hit     = ram_wr_en && (ram_wr_addr == ram_rd_addr);
    end

    assign ram_rd_en = acc_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end else if (acc_en) begin
            fwd_hit_reg <= fwd_hit;
            rd_vld_reg  <= ram_vld_reg[ram_rd_addr] | fwd_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_en) begin
            fwd_data_reg <= exec_item.data;
        end
    end

    // Latches, valid bits, tick step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHIPS; i++) begin
                latch_reg[i] <= '0;
            end
            ram_vld_reg   <= '0;
            tick_step_reg <= TICK_STEP_RESET;
        end else begin
            if (exec_en && x_latch_we) begin
                latch_reg[x_idx] <= exec_item.data[3:0];
            end
            if (ram_wr_en) begin
                ram_vld_reg[ram_wr_addr] <= 1'b1;
            end
            if (cfg_wr_en) begin
                tick_step_reg <= cfg_wr_data;
            end
        end
    end

    // Tick counter, modulo 10240
    always_comb begin
        count_sum = {1'b0, cycle_count_reg} + 15'(tick_step_reg);
        if (count_sum >= 15'(COUNT_WRAP)) begin
            cycle_count_next = 14'(count_sum - 15'(COUNT_WRAP));
        end else begin
            cycle_count_next = count_sum[13:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cycle_count_reg <= '0;
        end else if (exec_en && (x_op == OP_TICK)) begin
            cycle_count_reg <= cycle_count_next;
        end
    end

    // Result mux
    always_comb begin
        if (fwd_hit_reg) begin
            stored_data = fwd_data_reg;
        end else if (rd_vld_reg) begin
            stored_data = ram_rd_data;
        end else begin
            stored_data = 8'h00;
        end
        result = BUS_IDLE;
        if ((x_op == OP_READ) && x_mapped && (x_func == FN_READ)) begin
            if ((x_chip == TIMER_CHIP) && (x_reg == TIMER_REG)) begin
                result = timer_value(cycle_count_reg[13:10]);
            end else if (x_stored) begin
                result = stored_data;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cycle_count_reg < COUNT_WRAP)
        else $error("cycle count out of range");
`endif

endmodule

@@ sv/sound_chip_port_interface_top.sv @@
// Top level of the sound chip port interface: handshake registers and register-file RAM.
// Depends on scpi_pkg, scpi_ram and scpi_exec.

// Port front end for up to NUM_CHIPS sound chips on an audio CPU bus. Each
// transaction on the s_ channel is a port write, a port read, a time tick or a
// no-op; every transaction returns exactly one byte on the m_ channel (the read
// data, or 0xFF for writes, ticks, no-ops and unmapped reads), in order. The port
// byte splits into chip (port[7:2]) and function (port[1:0]); ports above 0x12
// are ignored. Throughput is one transaction per clock while m_ready is high: a
// transaction lands in the input register, is executed against the address
// latches, tick counter and register-file RAM in one pass, and its byte is held
// in the result register, which drives m_valid. The register-file RAM is read at
// the acceptance edge and written at the execute edge; writes that collide with
// the read are forwarded. Per-entry valid bits make the register file read as
// zero after reset with no clearing pass. The user must write tick_step through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce it.
module sound_chip_port_interface_top #(
    parameter int NUM_CHIPS        = scpi_pkg::NUM_CHIPS_DEF,
    parameter int NUM_STORED_CHIPS = scpi_pkg::NUM_STORED_CHIPS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_wr_en,
    input  logic [9:0] cfg_wr_data,
    // input transactions
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [7:0] s_port,
    input  logic [7:0] s_write_data,
    // result transactions
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data
);

    import scpi_pkg::*;

    localparam int RAM_DEPTH = NUM_STORED_CHIPS * REGS_PER_CHIP;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    logic              in_vld_reg, in_vld_next;
    item_t             in_item_reg;
    logic              out_vld_reg, out_vld_next;
    logic [7:0]        m_read_data_reg;
    logic              accept, advance;
    logic [7:0]        result;

    logic              ram_wr_en, ram_rd_en;
    logic [RAM_AW-1:0] ram_wr_addr, ram_rd_addr;
    logic [7:0]        ram_wr_data, ram_rd_data;

    // Input stage moves to the result register whenever that is empty or draining
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign accept  = s_valid && s_ready;

    always_comb begin
        in_vld_next  = accept || (in_vld_reg && !advance);
        out_vld_next = advance || (out_vld_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_item_reg <= '{opcode: s_opcode, port: s_port, data: s_write_data};
        end
        if (advance) begin
            m_read_data_reg <= result;
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_read_data = m_read_data_reg;

    scpi_exec #(
        .NUM_CHIPS        (NUM_CHIPS),
        .NUM_STORED_CHIPS (NUM_STORED_CHIPS)
    ) u_exec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .exec_en     (advance),
        .exec_item   (in_item_reg),
        .acc_en      (accept),
        .acc_port    (s_port),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .result      (result)
    );

    scpi_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_regfile (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

`ifndef ASSERT_OFF
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg && !m_ready))
        else $error("input stalled without a full pipeline");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_vld_reg)
        else $error("executed transaction lost");

    a_nonread_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_item_reg.opcode != OP_READ)) |=> (m_read_data == BUS_IDLE))
        else $error("non-read transaction returned data");
`endif

endmodule
